@@ rtl/cpspid_pkg.sv @@
// Package for the cascaded position/speed PID axis: widths, register indexes
// and reset values. No dependencies; used by the PID block, checker and bench.
package cpspid_pkg;

  // Fixed field widths
  localparam int POS_W   = 16;           // position target / reading
  localparam int SPD_W   = 16;           // speed reading
  localparam int DRV_W   = 16;           // drive output
  localparam int ST_W    = 24;           // speed target
  localparam int GAIN_W  = 32;           // Q16.16 gains
  localparam int LIM_W   = 15;           // drive limit
  localparam int INT_W   = 32;           // integrators
  localparam int FRAC_W  = 16;           // fractional bits of the gains
  localparam int PE_W    = POS_W + 1;    // position error
  localparam int PDE_W   = PE_W + 1;     // position error difference
  localparam int SE_W    = ST_W + 1;     // speed error
  localparam int SDE_W   = SE_W + 1;     // speed error difference

  // Digit-serial MAC
  localparam int DIG_W     = 4;                        // bits per digit
  localparam int OPND_W    = 32;                       // operand width
  localparam int DIGITS    = OPND_W / DIG_W;           // digits per operand
  localparam int DCNT_W    = $clog2(DIGITS);
  localparam int NUM_TERMS = 3;                        // P, I, D
  localparam int TERM_W    = $clog2(NUM_TERMS);
  localparam int PP_W      = GAIN_W + DIG_W + 1;       // gain x signed digit
  localparam int WIN_W     = PP_W + 3;                 // running window
  localparam int RND_W     = WIN_W + OPND_W - FRAC_W;  // rounded sum

  // Configuration registers
  localparam int NUM_GAINS = 2 * NUM_TERMS;
  localparam int GIDX_W    = $clog2(NUM_GAINS);
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = GAIN_W;

  typedef enum logic [CFG_AW-1:0] {
    REG_POS_P = 3'd0,
    REG_POS_I = 3'd1,
    REG_POS_D = 3'd2,
    REG_SPD_P = 3'd3,
    REG_SPD_I = 3'd4,
    REG_SPD_D = 3'd5,
    REG_LIMIT = 3'd6
  } cfg_idx_t;

  localparam logic signed [GAIN_W-1:0] GAIN_RST [NUM_GAINS] = '{
    -32'sd5898240,   // pos P, -90.0
    32'sd0,
    32'sd0,
    -32'sd196608,    // spd P, -3.0
    32'sd0,
    32'sd0
  };
  localparam logic [LIM_W-1:0] LIMIT_RST = 15'd5000;

  localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
  localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

endpackage

@@ rtl/cascaded_position_speed_pid.sv @@
// Cascaded position/speed PID for one axis, top level.
// Depends on cpspid_pkg (widths, register indexes, reset values).
//
// Usage:
//  - in_*: one word per control tick. in_tdata carries position_target,
//    position_reading and speed_reading; in_tuser carries the stop flag.
//  - out_*: one word per input word, drive and speed_target.
//  - cfg_*: gain and limit writes, one per cycle, only while the block is idle.
// Sequence: a normal word runs the position loop, then the speed loop, then
//  waits in done until the output register is free; out_tvalid rises from it.
//  Each loop runs its 3 terms through the shared 32x4 digit MAC, 8 digits
//  each, which sets the rate. A new word is taken only back in idle.
//  A stop word goes straight to done and out_tvalid rises once done loads
//  the output register; all loop state is left unchanged.
// Reset (rst_n low, synchronous) clears loop state, loads default gains and
//  limit and empties the output register.
// Stall: the result sits in an output register; a new input word is taken
//  while it waits. If the next result is ready before the old one is taken,
//  the block holds in its done state and accepts nothing until the slot frees.
module cascaded_position_speed_pid (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [15:0] position_target, [31:16] position_reading, [47:32] speed_reading
  input  logic [47:0]                   in_tdata,
  // [0] stop
  input  logic                          in_tuser,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [15:0] drive, [39:16] speed_target
  output logic [39:0]                   out_tdata,
  // configuration
  input  logic                          cfg_we,
  input  logic [cpspid_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [cpspid_pkg::CFG_DW-1:0] cfg_wdata
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_PREP_POS = 10'b0000000010,
    S_MAC_POS  = 10'b0000000100,
    S_RND_POS  = 10'b0000001000,
    S_SAT_POS  = 10'b0000010000,
    S_PREP_SPD = 10'b0000100000,
    S_MAC_SPD  = 10'b0001000000,
    S_RND_SPD  = 10'b0010000000,
    S_SAT_SPD  = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // config
  logic signed [cpspid_pkg::GAIN_W-1:0] gain_r [cpspid_pkg::NUM_GAINS];
  logic [cpspid_pkg::LIM_W-1:0]         limit_r;

  // latched inputs
  logic signed [cpspid_pkg::POS_W-1:0]  tgt_r, pos_r;
  logic signed [cpspid_pkg::SPD_W-1:0]  spd_r;

  // loop state
  logic signed [cpspid_pkg::INT_W-1:0]  pos_int_r, spd_int_r;
  logic signed [cpspid_pkg::PE_W-1:0]   pos_err_last_r, pos_err_before_r;
  logic signed [cpspid_pkg::SE_W-1:0]   spd_err_last_r, spd_err_before_r;
  logic signed [cpspid_pkg::ST_W-1:0]   last_st_r;

  // MAC datapath
  logic [cpspid_pkg::OPND_W-1:0]        opnd_r [cpspid_pkg::NUM_TERMS];
  logic [cpspid_pkg::DCNT_W-1:0]        dig_r;
  logic [cpspid_pkg::TERM_W-1:0]        term_r;
  logic signed [cpspid_pkg::WIN_W-1:0]  win_r;
  logic [cpspid_pkg::OPND_W-1:0]        lo_r;
  logic signed [cpspid_pkg::RND_W-1:0]  rnd_r;
  logic signed [cpspid_pkg::DRV_W-1:0]  drv_r;

  // output register
  logic                                 out_valid_r;
  logic signed [cpspid_pkg::DRV_W-1:0]  out_drv_r;
  logic signed [cpspid_pkg::ST_W-1:0]   out_st_r;

  // combinational
  logic                                 in_acc;
  logic                                 out_load;
  logic signed [cpspid_pkg::PE_W-1:0]   pe;
  logic signed [cpspid_pkg::PDE_W-1:0]  pde;
  logic signed [cpspid_pkg::SE_W-1:0]   se;
  logic signed [cpspid_pkg::SDE_W-1:0]  sde;
  logic signed [cpspid_pkg::INT_W-1:0]  pos_int_nxt, spd_int_nxt;
  logic [cpspid_pkg::GIDX_W-1:0]        gain_idx;
  logic signed [cpspid_pkg::GAIN_W-1:0] gain_sel;
  logic [cpspid_pkg::DIG_W-1:0]         dig;
  logic signed [cpspid_pkg::DIG_W:0]    dig_s;
  logic signed [cpspid_pkg::PP_W-1:0]   pp;
  logic signed [cpspid_pkg::WIN_W-1:0]  mac_sum;
  logic signed [cpspid_pkg::RND_W-1:0]  rnd_nxt;
  logic signed [cpspid_pkg::ST_W-1:0]   st_sat;
  logic signed [cpspid_pkg::RND_W-1:0]  lim_ext;
  logic signed [cpspid_pkg::DRV_W-1:0]  lim_drv;
  logic signed [cpspid_pkg::DRV_W-1:0]  drv_sat;
  logic                                 last_term, last_dig;

  // saturating integrator add, 32-bit bounds
  function automatic logic signed [cpspid_pkg::INT_W-1:0] int_add(
    input logic signed [cpspid_pkg::INT_W-1:0] a,
    input logic signed [cpspid_pkg::SE_W-1:0]  b
  );
    logic signed [cpspid_pkg::INT_W:0] s;
    s = (cpspid_pkg::INT_W+1)'(a) + (cpspid_pkg::INT_W+1)'(b);
    if (s[cpspid_pkg::INT_W] != s[cpspid_pkg::INT_W-1])
      int_add = {s[cpspid_pkg::INT_W], {(cpspid_pkg::INT_W-1){~s[cpspid_pkg::INT_W]}}};
    else
      int_add = s[cpspid_pkg::INT_W-1:0];
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_st_r, out_drv_r};
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // loop errors and integrator updates
  assign pe  = cpspid_pkg::PE_W'(tgt_r) - cpspid_pkg::PE_W'(pos_r);
  assign pde = cpspid_pkg::PDE_W'(pos_err_last_r) - cpspid_pkg::PDE_W'(pos_err_before_r);
  assign se  = cpspid_pkg::SE_W'(last_st_r) - cpspid_pkg::SE_W'(spd_r);
  assign sde = cpspid_pkg::SDE_W'(spd_err_last_r) - cpspid_pkg::SDE_W'(spd_err_before_r);
  assign pos_int_nxt = int_add(pos_int_r, cpspid_pkg::SE_W'(pe));
  assign spd_int_nxt = int_add(spd_int_r, se);

  // MAC: window += gain * digit; after the third term, shift one digit out.
  // Digits go LSB first; the top digit carries the operand's sign.
  assign gain_idx  = cpspid_pkg::GIDX_W'(term_r)
                   + ((state_r == S_MAC_SPD) ? cpspid_pkg::GIDX_W'(cpspid_pkg::NUM_TERMS)
                                             : cpspid_pkg::GIDX_W'(0));
  assign gain_sel  = gain_r[gain_idx];
  assign dig       = opnd_r[term_r][cpspid_pkg::DIG_W-1:0];
  assign last_dig  = (dig_r == cpspid_pkg::DCNT_W'(cpspid_pkg::DIGITS - 1));
  assign last_term = (term_r == cpspid_pkg::TERM_W'(cpspid_pkg::NUM_TERMS - 1));
  assign dig_s     = last_dig ? {dig[cpspid_pkg::DIG_W-1], dig} : {1'b0, dig};
  assign pp        = gain_sel * dig_s;
  assign mac_sum   = win_r + cpspid_pkg::WIN_W'(pp);

  // round Q16.16 to nearest, ties up: floor((s + 0x8000) / 0x10000)
  assign rnd_nxt = $signed({win_r, lo_r[cpspid_pkg::OPND_W-1:cpspid_pkg::FRAC_W]})
                 + cpspid_pkg::RND_W'({1'b0, lo_r[cpspid_pkg::FRAC_W-1]});

  // outer result: negate, saturate to 24 bits
  always_comb begin
    if (rnd_r < -cpspid_pkg::RND_W'(cpspid_pkg::ST_MAX))
      st_sat = cpspid_pkg::ST_MAX;
    else if (rnd_r > -cpspid_pkg::RND_W'(cpspid_pkg::ST_MIN))
      st_sat = cpspid_pkg::ST_MIN;
    else
      st_sat = -rnd_r[cpspid_pkg::ST_W-1:0];
  end

  // inner result: clamp to +/- limit
  assign lim_ext = cpspid_pkg::RND_W'({1'b0, limit_r});
  assign lim_drv = cpspid_pkg::DRV_W'({1'b0, limit_r});
  always_comb begin
    if (rnd_r > lim_ext)
      drv_sat = lim_drv;
    else if (rnd_r < -lim_ext)
      drv_sat = -lim_drv;
    else
      drv_sat = rnd_r[cpspid_pkg::DRV_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_acc) state_nxt = in_tuser ? S_DONE : S_PREP_POS;
      S_PREP_POS: state_nxt = S_MAC_POS;
      S_MAC_POS:  if (last_dig && last_term) state_nxt = S_RND_POS;
      S_RND_POS:  state_nxt = S_SAT_POS;
      S_SAT_POS:  state_nxt = S_PREP_SPD;
      S_PREP_SPD: state_nxt = S_MAC_SPD;
      S_MAC_SPD:  if (last_dig && last_term) state_nxt = S_RND_SPD;
      S_RND_SPD:  state_nxt = S_SAT_SPD;
      S_SAT_SPD:  state_nxt = S_DONE;
      S_DONE:     if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cpspid_pkg::NUM_GAINS; i++) gain_r[i] <= cpspid_pkg::GAIN_RST[i];
      limit_r <= cpspid_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr) inside
        cpspid_pkg::REG_POS_P, cpspid_pkg::REG_POS_I, cpspid_pkg::REG_POS_D,
        cpspid_pkg::REG_SPD_P, cpspid_pkg::REG_SPD_I, cpspid_pkg::REG_SPD_D: begin
          gain_r[cpspid_pkg::GIDX_W'(cfg_addr)] <= cfg_wdata;
        end
        cpspid_pkg::REG_LIMIT: begin
          limit_r <= cfg_wdata[cpspid_pkg::LIM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // loop state: committed once per accepted non-stop word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_int_r        <= '0;
      pos_err_last_r   <= '0;
      pos_err_before_r <= '0;
      spd_int_r        <= '0;
      spd_err_last_r   <= '0;
      spd_err_before_r <= '0;
      last_st_r        <= '0;
    end else begin
      if (state_r == S_PREP_POS) begin
        pos_int_r        <= pos_int_nxt;
        pos_err_before_r <= pos_err_last_r;
        pos_err_last_r   <= pe;
      end
      if (state_r == S_SAT_POS) begin
        last_st_r <= st_sat;
      end
      if (state_r == S_PREP_SPD) begin
        spd_int_r        <= spd_int_nxt;
        spd_err_before_r <= spd_err_last_r;
        spd_err_last_r   <= se;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_r  <= '0;
      term_r <= '0;
    end else begin
      if (state_r == S_PREP_POS || state_r == S_PREP_SPD) begin
        dig_r  <= '0;
        term_r <= '0;
      end else if (state_r == S_MAC_POS || state_r == S_MAC_SPD) begin
        if (last_term) begin
          term_r <= '0;
          dig_r  <= dig_r + cpspid_pkg::DCNT_W'(1);
        end else begin
          term_r <= term_r + cpspid_pkg::TERM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_r <= in_tdata[cpspid_pkg::POS_W-1:0];
      pos_r <= in_tdata[2*cpspid_pkg::POS_W-1:cpspid_pkg::POS_W];
      spd_r <= in_tdata[2*cpspid_pkg::POS_W+cpspid_pkg::SPD_W-1:2*cpspid_pkg::POS_W];
    end
    unique case (state_r)
      S_PREP_POS: begin
        opnd_r[0] <= cpspid_pkg::OPND_W'(pe);
        opnd_r[1] <= cpspid_pkg::OPND_W'(pos_int_nxt);
        opnd_r[2] <= cpspid_pkg::OPND_W'(pde);
        win_r     <= '0;
      end
      S_PREP_SPD: begin
        opnd_r[0] <= cpspid_pkg::OPND_W'(se);
        opnd_r[1] <= cpspid_pkg::OPND_W'(spd_int_nxt);
        opnd_r[2] <= cpspid_pkg::OPND_W'(sde);
        win_r     <= '0;
      end
      S_MAC_POS, S_MAC_SPD: begin
        opnd_r[term_r] <= opnd_r[term_r] >> cpspid_pkg::DIG_W;
        if (last_term) begin
          win_r <= mac_sum >>> cpspid_pkg::DIG_W;
          lo_r  <= {mac_sum[cpspid_pkg::DIG_W-1:0],
                    lo_r[cpspid_pkg::OPND_W-1:cpspid_pkg::DIG_W]};
        end else begin
          win_r <= mac_sum;
        end
      end
      S_RND_POS, S_RND_SPD: rnd_r <= rnd_nxt;
      S_SAT_SPD: drv_r <= drv_sat;
      S_IDLE: if (in_acc && in_tuser) drv_r <= '0;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drv_r <= drv_r;
      out_st_r  <= last_st_r;
    end
  end

  // checks
  a_stop_short: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> state_r == S_DONE)
    else $error("stop word did not go straight to done");

  a_mac_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PREP_POS || state_r == S_PREP_SPD |=> dig_r == '0 && term_r == '0)
    else $error("MAC counters not cleared at loop start");

  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC_POS || state_r == S_MAC_SPD
      |-> term_r <= cpspid_pkg::TERM_W'(cpspid_pkg::NUM_TERMS - 1))
    else $error("MAC term counter out of range");

  a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SAT_SPD |=>
      drv_r <= $signed({1'b0, $past(limit_r)}) && drv_r >= -$signed({1'b0, $past(limit_r)}))
    else $error("drive outside limit");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("output loaded outside done state");

endmodule

@@ bench/cpspid_checker.sv @@
// Result checker for cascaded_position_speed_pid: mirrors the gain and limit
// registers, predicts one result word per accepted input word and compares.
// Depends on cpspid_pkg (widths, register indexes, reset values).
module cpspid_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [47:0]                   in_tdata,
  input  logic                          in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [39:0]                   out_tdata,
  input  logic                          cfg_we,
  input  logic [cpspid_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [cpspid_pkg::CFG_DW-1:0] cfg_wdata,
  output int                            mismatches,
  output int                            pending,
  output int                            checked
);

  localparam longint I32_HI = 64'sd2147483647;
  localparam longint I32_LO = -64'sd2147483648;

  // drive sits in the low bits of out_tdata
  typedef struct packed {
    logic signed [cpspid_pkg::ST_W-1:0]  spd_target;
    logic signed [cpspid_pkg::DRV_W-1:0] drive;
  } axis_cmd_t;

  logic signed [cpspid_pkg::GAIN_W-1:0] kp_pos, ki_pos, kd_pos, kp_spd, ki_spd, kd_spd;
  logic [cpspid_pkg::LIM_W-1:0]         drive_lim;
  logic signed [cpspid_pkg::INT_W-1:0]  pos_sum, spd_sum;
  logic signed [cpspid_pkg::PE_W-1:0]   pos_e1, pos_e2;
  logic signed [cpspid_pkg::SE_W-1:0]   spd_e1, spd_e2;
  logic signed [cpspid_pkg::ST_W-1:0]   held_target;
  axis_cmd_t                            cmd_q[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Q16.16 to integer, nearest, ties up
  function automatic longint q16_to_int(longint v);
    return (v + 64'sd32768) >>> cpspid_pkg::FRAC_W;
  endfunction

  function automatic axis_cmd_t run_tick(logic signed [cpspid_pkg::POS_W-1:0] tgt,
                                         logic signed [cpspid_pkg::POS_W-1:0] pos,
                                         logic signed [cpspid_pkg::SPD_W-1:0] spd,
                                         logic halt);
    longint pe, pde, se, sde, acc, st, drv;
    axis_cmd_t r;
    if (halt) begin
      r.drive      = '0;
      r.spd_target = held_target;
      return r;
    end
    // position loop
    pe      = longint'(tgt) - longint'(pos);
    pos_sum = cpspid_pkg::INT_W'(clip(longint'(pos_sum) + pe, I32_LO, I32_HI));
    pde     = longint'(pos_e1) - longint'(pos_e2);
    pos_e2  = pos_e1;
    pos_e1  = cpspid_pkg::PE_W'(pe);
    acc = longint'(kp_pos) * pe + longint'(ki_pos) * longint'(pos_sum)
        + longint'(kd_pos) * pde;
    st  = clip(-q16_to_int(acc), longint'(cpspid_pkg::ST_MIN), longint'(cpspid_pkg::ST_MAX));
    held_target = cpspid_pkg::ST_W'(st);
    // speed loop
    se      = st - longint'(spd);
    spd_sum = cpspid_pkg::INT_W'(clip(longint'(spd_sum) + se, I32_LO, I32_HI));
    sde     = longint'(spd_e1) - longint'(spd_e2);
    spd_e2  = spd_e1;
    spd_e1  = cpspid_pkg::SE_W'(se);
    acc = longint'(kp_spd) * se + longint'(ki_spd) * longint'(spd_sum)
        + longint'(kd_spd) * sde;
    drv = clip(q16_to_int(acc), -longint'(drive_lim), longint'(drive_lim));
    r.drive      = cpspid_pkg::DRV_W'(drv);
    r.spd_target = cpspid_pkg::ST_W'(st);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    axis_cmd_t got, want;
    if (!rst_n) begin
      kp_pos = cpspid_pkg::GAIN_RST[0];
      ki_pos = cpspid_pkg::GAIN_RST[1];
      kd_pos = cpspid_pkg::GAIN_RST[2];
      kp_spd = cpspid_pkg::GAIN_RST[3];
      ki_spd = cpspid_pkg::GAIN_RST[4];
      kd_spd = cpspid_pkg::GAIN_RST[5];
      drive_lim   = cpspid_pkg::LIMIT_RST;
      pos_sum     = '0; pos_e1 = '0; pos_e2 = '0;
      spd_sum     = '0; spd_e1 = '0; spd_e2 = '0;
      held_target = '0;
      cmd_q.delete();
      mismatches  = 0;
      checked     = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          cpspid_pkg::REG_POS_P: kp_pos = cfg_wdata;
          cpspid_pkg::REG_POS_I: ki_pos = cfg_wdata;
          cpspid_pkg::REG_POS_D: kd_pos = cfg_wdata;
          cpspid_pkg::REG_SPD_P: kp_spd = cfg_wdata;
          cpspid_pkg::REG_SPD_I: ki_spd = cfg_wdata;
          cpspid_pkg::REG_SPD_D: kd_spd = cfg_wdata;
          cpspid_pkg::REG_LIMIT: drive_lim = cfg_wdata[cpspid_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        cmd_q.push_back(run_tick(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32],
                                 in_tuser));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (cmd_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got drive %0d speed_target %0d",
                   $time, got.drive, got.spd_target);
        end else begin
          want = cmd_q.pop_front();
          checked++;
          if (got.drive !== want.drive) begin
            mismatches++;
            $display("%0t: drive expected %0d got %0d", $time, want.drive, got.drive);
          end
          if (got.spd_target !== want.spd_target) begin
            mismatches++;
            $display("%0t: speed_target expected %0d got %0d",
                     $time, want.spd_target, got.spd_target);
          end
        end
      end
    end
    pending = cmd_q.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the bench for cascaded_position_speed_pid: clock, reset, stimulus
// and verdict. Depends on cpspid_pkg, the block and cpspid_checker.
module testbench;

  // worst case is about 1600 words, each with the block's computation plus a
  // long gap and a long stall; this limit leaves ample headroom
  localparam int CYCLE_LIMIT = 2_000_000;
  // index past the last register; writes there must be dropped
  localparam logic [cpspid_pkg::CFG_AW-1:0] REG_UNUSED = 3'd7;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic [47:0]                   in_tdata   = '0;
  logic                          in_tuser   = 1'b0;
  logic                          out_tready = 1'b0;
  logic                          cfg_we     = 1'b0;
  logic [cpspid_pkg::CFG_AW-1:0] cfg_addr   = '0;
  logic [cpspid_pkg::CFG_DW-1:0] cfg_wdata  = '0;
  wire                           in_tready;
  wire                           out_tvalid;
  wire  [39:0]                   out_tdata;

  int mismatches, pending, checked;
  int cycles      = 0;
  int stall_left  = 0;
  int ticks_sent  = 0;
  int stops_sent  = 0;
  int settings    = 0;
  bit steady_tx   = 1'b0;  // no input gaps while set
  bit steady_rx   = 1'b0;  // receiver never stalls while set

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cascaded_position_speed_pid DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] target, [31:16] position, [47:32] speed
    .in_tuser   (in_tuser),   // [0] stop
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] drive, [39:16] speed_target
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  cpspid_checker axis_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // Mostly no gap, often a few cycles, now and then long, at times longer than
  // a whole tick, so that gaps land on every stage of the computation.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 100);
  endfunction

  // Receiver: random stalls, including ones long enough to hold the block
  // in its done state with the next result ready.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!steady_rx && $urandom_range(0, 11) == 0) begin
      stall_left = pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One control tick. Called at a rising edge; returns at the edge where the
  // word is taken. in_tready is looked at on the falling edge, where it is
  // stable, so acceptance never hinges on event order at the rising edge.
  task automatic send_tick(input logic signed [15:0] tgt, input logic signed [15:0] pos,
                           input logic signed [15:0] spd, input logic halt);
    int gap;
    gap = steady_tx ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {spd, pos, tgt};
    in_tuser  <= halt;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    ticks_sent++;
    if (halt) stops_sent++;
  endtask

  // Drop valid and wait until every expected word has come back.
  task automatic go_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cpspid_pkg::CFG_AW-1:0] idx,
                           input logic [cpspid_pkg::CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Rewrites all seven registers, only with the block idle. Sometimes a stray
  // write to the unused index goes first; the block must ignore it.
  task automatic load_gains(input logic [31:0] pos_kp, input logic [31:0] pos_ki,
                            input logic [31:0] pos_kd, input logic [31:0] spd_kp,
                            input logic [31:0] spd_ki, input logic [31:0] spd_kd,
                            input logic [14:0] lim);
    go_idle();
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, $urandom);
    write_reg(cpspid_pkg::REG_POS_P, pos_kp);
    write_reg(cpspid_pkg::REG_POS_I, pos_ki);
    write_reg(cpspid_pkg::REG_POS_D, pos_kd);
    write_reg(cpspid_pkg::REG_SPD_P, spd_kp);
    write_reg(cpspid_pkg::REG_SPD_I, spd_ki);
    write_reg(cpspid_pkg::REG_SPD_D, spd_kd);
    write_reg(cpspid_pkg::REG_LIMIT, {17'b0, lim});
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Signed Q16.16 gain within +/- mag.
  function automatic logic [31:0] small_gain(int mag);
    return 32'(int'($urandom_range(0, 2 * mag)) - mag);
  endfunction

  // Mix of full-range words (every bit toggles) and words whose target sits
  // near the reading, which keeps the loops out of saturation at moderate gains.
  task automatic random_ticks(input int count, input int spread, input int stop_odds);
    logic signed [15:0] tgt, pos, spd;
    for (int i = 0; i < count; i++) begin
      pos = 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        tgt = 16'($urandom);
        spd = 16'($urandom);
      end else begin
        tgt = pos + 16'(int'($urandom_range(0, 2 * spread)) - spread);
        spd = 16'(int'($urandom_range(0, 4000)) - 2000);
      end
      send_tick(tgt, pos, spd, $urandom_range(1, stop_odds) == 1);
    end
  endtask

  // Large error of one sign: with the position gain at its most negative the
  // speed target pins at a rail and the speed integrator runs into its bound.
  task automatic windup_ticks(input int count, input bit upward);
    logic signed [15:0] tgt, pos;
    for (int i = 0; i < count; i++) begin
      tgt = 16'($urandom_range(1000, 32767));
      pos = 16'($urandom_range(0, 600));
      if (!upward) begin
        tgt = -tgt;
        pos = -pos;
      end
      send_tick(tgt, pos, 16'($urandom), $urandom_range(0, 39) == 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset gains: field extremes, stop with extreme
    // readings (must echo the held speed target), single-count errors.
    send_tick(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_tick(16'sd32767, -16'sd32768, 16'sd0, 1'b0);
    send_tick(-16'sd32768, 16'sd32767, 16'sd0, 1'b0);
    send_tick(16'sd32767, 16'sd32767, -16'sd32768, 1'b1);
    send_tick(16'sd0, 16'sd0, 16'sd32767, 1'b0);
    send_tick(16'sd0, 16'sd0, -16'sd32768, 1'b0);
    send_tick(-16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
    send_tick(16'sd1, 16'sd0, 16'sd0, 1'b0);
    send_tick(16'sd0, 16'sd1, -16'sd1, 1'b0);

    // Half gains: products land exactly on .5, both signs, for the tie rule.
    load_gains(32'h0000_8000, '0, '0, 32'h0000_8000, '0, '0, 15'd32767);
    send_tick(16'sd1, 16'sd0, 16'sd0, 1'b0);
    send_tick(16'sd0, 16'sd1, 16'sd0, 1'b0);
    send_tick(16'sd3, 16'sd0, 16'sd0, 1'b0);
    send_tick(16'sd0, 16'sd0, 16'sd1, 1'b0);
    send_tick(16'sd0, 16'sd0, -16'sd1, 1'b0);
    send_tick(-16'sd3, 16'sd0, 16'sd0, 1'b0);

    // Integral and derivative terms alone, limit of one count.
    load_gains('0, 32'h0000_8000, 32'h0000_8000, '0, 32'h0000_8000, 32'h0000_8000, 15'd1);
    send_tick(16'sd5, 16'sd0, 16'sd0, 1'b0);
    send_tick(-16'sd2, 16'sd0, 16'sd0, 1'b0);
    send_tick(16'sd0, 16'sd0, 16'sd7, 1'b0);
    send_tick(16'sd0, 16'sd0, 16'sd0, 1'b1);

    // Moderate random gains: once with random idling, once back to back.
    load_gains(small_gain(4 << 16), small_gain(1 << 14), small_gain(2 << 16),
               small_gain(4 << 16), small_gain(1 << 14), small_gain(2 << 16),
               15'($urandom_range(100, 32767)));
    random_ticks(100, 300, 8);
    load_gains(small_gain(4 << 16), small_gain(1 << 14), small_gain(2 << 16),
               small_gain(4 << 16), small_gain(1 << 14), small_gain(2 << 16),
               15'($urandom_range(100, 32767)));
    steady_tx = 1'b1;
    steady_rx = 1'b1;
    random_ticks(100, 300, 8);
    steady_tx = 1'b0;
    steady_rx = 1'b0;

    // Register extremes: every gain at its top with the widest limit, then
    // every gain at its bottom with a zero limit (drive must stay at 0).
    load_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 15'd32767);
    random_ticks(100, 2000, 10);
    load_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 15'd0);
    random_ticks(100, 2000, 10);

    // Integrator windup: drive follows the speed integral alone, so the
    // climb off each bound shows whether the bound was held.
    load_gains(32'h8000_0000, '0, '0, '0, 32'h0000_0001, '0, 15'd32767);
    windup_ticks(275, 1'b1);
    windup_ticks(545, 1'b0);
    windup_ticks(30, 1'b1);

    // Fully random registers.
    repeat (2) begin
      load_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 15'($urandom_range(0, 32767)));
      random_ticks(100, 1000, 8);
    end

    // Near the default tuning with small I and D terms, small errors.
    load_gains(-32'sd5898240, small_gain(64), small_gain(1 << 16),
               -32'sd196608, small_gain(256), small_gain(1 << 15), 15'd5000);
    random_ticks(150, 100, 8);

    // Drain, then allow a full tick of latency for anything stray.
    go_idle();
    repeat (80) @(posedge clk);
    @(negedge clk);
    $display("%0d control ticks sent (%0d with stop) over %0d register settings",
             ticks_sent, stops_sent, settings);
    $display("%0d result words checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cpspid_pkg.sv
rtl/cascaded_position_speed_pid.sv
bench/cpspid_checker.sv
bench/testbench.sv
